### hdl/hvcps_pkg.sv
// Package for the high-voltage charge supervisor: shared widths, constants,
// register indexes and the structs passed between its modules.
// No dependencies.
package hvcps_pkg;

   localparam int LEVEL_BITS    = 4;
   localparam int TARGET_BITS   = 10;
   localparam int TABLE_BITS    = 40;
   localparam int GAIN_BITS     = 8;
   localparam int THR_BITS      = 10;
   localparam int WORD_BITS     = 16;
   localparam int PROD_BITS     = WORD_BITS + GAIN_BITS;
   localparam int CMP_BITS      = 18;
   localparam int RUN_BITS      = 3;
   localparam int TICK_BITS     = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 40;
   localparam int SLOT_BITS     = 2;

   localparam int WINDOW_HALF   = 3;
   localparam int OVER_MARGIN   = 50;
   localparam int TIMEOUT_TICKS = 200;
   localparam int RUN_FOR_FULL  = 4;
   localparam int KP_RESET      = 14;
   localparam int KD_RESET      = 4;
   localparam int LEVEL_FIRST   = 1;
   localparam int LEVEL_LAST    = 8;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_TARGETS_LOW     = 3'd0,
      REG_TARGETS_HIGH    = 3'd1,
      REG_KP_GAIN         = 3'd2,
      REG_KD_GAIN         = 3'd3,
      REG_START_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TABLE_BITS-1:0] targets_low;
      logic [TABLE_BITS-1:0] targets_high;
      logic [GAIN_BITS-1:0]  kp_gain;
      logic [GAIN_BITS-1:0]  kd_gain;
      logic [THR_BITS-1:0]   start_threshold;
   } cfg_type;

   typedef struct packed {
      logic                 in_window;
      logic                 over;
      logic                 below_start;
      logic [WORD_BITS-1:0] err;
      logic [WORD_BITS-1:0] kp_err;
      logic [WORD_BITS-1:0] kd_err;
   } stage_type;

endpackage

### hdl/hvcps_if.sv
// Valid/ready channel interfaces for the charge supervisor's request and
// response items. Depends on hvcps_pkg.
interface hvcps_req_if #(
   parameter int SAMPLE_BITS = 10
);
   import hvcps_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LEVEL_BITS-1:0]  level_select;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, level_select, sample, input ready);
   modport sink   (input valid, level_select, sample, output ready);
endinterface

interface hvcps_rsp_if;
   import hvcps_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 drive_on;
   logic                 reload_valid;
   logic [WORD_BITS-1:0] reload_value;
   logic                 full_charge;
   logic                 over_voltage;
   logic                 timed_out;

   modport source (output valid, drive_on, reload_valid, reload_value, full_charge,
                   over_voltage, timed_out, input ready);
   modport sink   (input valid, drive_on, reload_valid, reload_value, full_charge,
                   over_voltage, timed_out, output ready);
endinterface

### hdl/hvcps_csr.sv
// Configuration registers of the charge supervisor, written through a plain
// write port. Depends on hvcps_pkg.
module hvcps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  hvcps_pkg::csr_index_type             csr_index,
   input  logic [hvcps_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output hvcps_pkg::cfg_type                   cfg
);
   import hvcps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_TARGETS_LOW:     cfg_in.targets_low     = csr_wdata[TABLE_BITS-1:0];
            REG_TARGETS_HIGH:    cfg_in.targets_high    = csr_wdata[TABLE_BITS-1:0];
            REG_KP_GAIN:         cfg_in.kp_gain         = csr_wdata[GAIN_BITS-1:0];
            REG_KD_GAIN:         cfg_in.kd_gain         = csr_wdata[GAIN_BITS-1:0];
            REG_START_THRESHOLD: cfg_in.start_threshold = csr_wdata[THR_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.targets_low     <= '0;
         cfg_ff.targets_high    <= '0;
         cfg_ff.kp_gain         <= GAIN_BITS'(KP_RESET);
         cfg_ff.kd_gain         <= GAIN_BITS'(KD_RESET);
         cfg_ff.start_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/hvcps_front.sv
// First stage: target lookup, window compares and the two gain products that
// do not depend on controller state. Depends on hvcps_pkg and hvcps_if.
module hvcps_front #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hvcps_pkg::cfg_type    cfg,
   hvcps_req_if.sink             req,
   input  logic                  take,
   output logic                  stage_vld,
   output hvcps_pkg::stage_type  stage
);
   import hvcps_pkg::*;

   localparam logic signed [CMP_BITS-1:0] WIN_S  = CMP_BITS'(WINDOW_HALF);
   localparam logic signed [CMP_BITS-1:0] OVER_S = CMP_BITS'(OVER_MARGIN);

   logic                         vld_ff;
   logic                         vld_in;
   stage_type                    stage_ff;
   stage_type                    stage_in;
   logic                         load;
   logic                         level_ok;
   logic [SLOT_BITS-1:0]         slot;
   logic [TABLE_BITS-1:0]        table_sel;
   logic [TARGET_BITS-1:0]       target;
   logic signed [CMP_BITS-1:0]   smp_s;
   logic signed [CMP_BITS-1:0]   tgt_s;
   logic [CMP_BITS-1:0]          smp_u;
   logic [CMP_BITS-1:0]          thr_u;
   logic [WORD_BITS-1:0]         err;
   logic [PROD_BITS-1:0]         kp_prod;
   logic [PROD_BITS-1:0]         kd_prod;

   assign req.ready = !vld_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      level_ok  = (req.level_select >= LEVEL_BITS'(LEVEL_FIRST))
               && (req.level_select <= LEVEL_BITS'(LEVEL_LAST));
      slot      = SLOT_BITS'(req.level_select - LEVEL_BITS'(LEVEL_FIRST));
      table_sel = (req.level_select > LEVEL_BITS'(RUN_FOR_FULL)) ? cfg.targets_high
                                                                 : cfg.targets_low;
      target    = level_ok ? table_sel[slot*TARGET_BITS +: TARGET_BITS] : '0;

      smp_s = signed'(CMP_BITS'(req.sample));
      tgt_s = signed'(CMP_BITS'(target));
      smp_u = CMP_BITS'(req.sample);
      thr_u = CMP_BITS'(cfg.start_threshold);

      err     = WORD_BITS'(target) - WORD_BITS'(req.sample);
      kp_prod = PROD_BITS'(cfg.kp_gain) * PROD_BITS'(err);
      kd_prod = PROD_BITS'(cfg.kd_gain) * PROD_BITS'(err);

      stage_in.in_window   = (smp_s <= tgt_s + WIN_S) && (smp_s >= tgt_s - WIN_S);
      stage_in.over        = smp_s >= tgt_s + OVER_S;
      stage_in.below_start = smp_u <= thr_u;
      stage_in.err         = err;
      stage_in.kp_err      = kp_prod[WORD_BITS-1:0];
      stage_in.kd_err      = kd_prod[WORD_BITS-1:0];

      vld_in = load ? 1'b1 : (take ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_vld = vld_ff;
   assign stage     = stage_ff;

endmodule

### hdl/hvcps_core.sv
// Second stage: window supervision state, the derivative term, drive decision
// and the response register. Depends on hvcps_pkg and hvcps_if.
module hvcps_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hvcps_pkg::GAIN_BITS-1:0] kd_gain,
   input  logic                          stage_vld,
   input  hvcps_pkg::stage_type          stage,
   output logic                          take,
   hvcps_rsp_if.source                   rsp
);
   import hvcps_pkg::*;

   logic [RUN_BITS-1:0]  run_ff,  run_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic                 full_ff, full_in;
   logic                 over_ff, over_in;
   logic                 tmo_ff,  tmo_in;
   logic [WORD_BITS-1:0] prev_ff, prev_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 drive_ff, drive_in;
   logic                 rvalid_ff, rvalid_in;
   logic [WORD_BITS-1:0] rvalue_ff, rvalue_in;
   logic                 done;
   logic [PROD_BITS-1:0] kd_prev;
   logic [WORD_BITS-1:0] pd_out;

   assign take = stage_vld && (!rsp_vld_ff || rsp.ready);

   always_comb begin
      run_in    = run_ff;
      ticks_in  = ticks_ff;
      full_in   = full_ff;
      over_in   = over_ff;
      tmo_in    = tmo_ff;
      prev_in   = prev_ff;
      drive_in  = 1'b0;
      rvalid_in = 1'b0;
      rvalue_in = '0;
      done      = 1'b0;
      kd_prev   = PROD_BITS'(kd_gain) * PROD_BITS'(prev_ff);
      pd_out    = stage.kp_err + stage.kd_err - kd_prev[WORD_BITS-1:0];

      if (stage.in_window) begin
         run_in   = run_ff + RUN_BITS'(1);
         ticks_in = '0;
         over_in  = 1'b0;
         if (run_in == RUN_BITS'(RUN_FOR_FULL)) begin
            full_in = 1'b1;
            run_in  = '0;
         end
      end else begin
         run_in  = '0;
         full_in = 1'b0;
         if (stage.over) begin
            over_in = 1'b1;
            done    = 1'b1;
         end else begin
            ticks_in = ticks_ff + TICK_BITS'(1);
            if (ticks_in == TICK_BITS'(TIMEOUT_TICKS)) begin
               tmo_in = 1'b1;
               done   = 1'b1;
            end
         end
      end

      if (!done) begin
         if (stage.below_start) begin
            drive_in = 1'b1;
         end else begin
            prev_in = stage.err;
            if (!pd_out[WORD_BITS-1] && (pd_out != '0)) begin
               drive_in  = 1'b1;
               rvalid_in = 1'b1;
               rvalue_in = pd_out;
            end
         end
      end

      rsp_vld_in = take ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         ticks_ff   <= '0;
         full_ff    <= 1'b0;
         over_ff    <= 1'b0;
         tmo_ff     <= 1'b0;
         prev_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (take) begin
            run_ff   <= run_in;
            ticks_ff <= ticks_in;
            full_ff  <= full_in;
            over_ff  <= over_in;
            tmo_ff   <= tmo_in;
            prev_ff  <= prev_in;
         end
      end
      if (take) begin
         drive_ff  <= drive_in;
         rvalid_ff <= rvalid_in;
         rvalue_ff <= rvalue_in;
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.drive_on     = drive_ff;
   assign rsp.reload_valid = rvalid_ff;
   assign rsp.reload_value = rvalue_ff;
   assign rsp.full_charge  = full_ff;
   assign rsp.over_voltage = over_ff;
   assign rsp.timed_out    = tmo_ff;

endmodule

### hdl/hv_charge_pd_supervisor.sv
// A request item is registered first in the front stage register, then in the response register.
// Throughput: one item per cycle; the request side stalls only while the
// response register is full and not taken.
// Reset (synchronous, active high) clears the window counters, the flags and
// the stored error, and returns the gains and thresholds to their defaults.
// Top level of the charge supervisor. Depends on hvcps_pkg, hvcps_if,
// hvcps_csr, hvcps_front and hvcps_core.
module hv_charge_pd_supervisor #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   hvcps_req_if.sink                           req,
   hvcps_rsp_if.source                         rsp,
   input  logic                                csr_wr_en,
   input  hvcps_pkg::csr_index_type            csr_index,
   input  logic [hvcps_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import hvcps_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      stage_vld;
   logic      take;

   hvcps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hvcps_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .take      (take),
      .stage_vld (stage_vld),
      .stage     (stage)
   );

   hvcps_core u_core (
      .clock     (clock),
      .reset     (reset),
      .kd_gain   (cfg.kd_gain),
      .stage_vld (stage_vld),
      .stage     (stage),
      .take      (take),
      .rsp       (rsp)
   );

endmodule

### hdl/hvcps_checker.sv
// Port-level checks of the charge supervisor's response items, bound to the
// top level. Depends on hvcps_pkg and hv_charge_pd_supervisor.
module hvcps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            drive_on,
   input logic                            reload_valid,
   input logic [hvcps_pkg::WORD_BITS-1:0] reload_value,
   input logic                            full_charge,
   input logic                            over_voltage
);
   import hvcps_pkg::*;

   // A loaded reload value is a positive controller output and turns drive on.
   a_reload_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && reload_valid |->
         drive_on && !reload_value[WORD_BITS-1] && (reload_value != '0))
      else $error("reload item is not a positive output with drive on");

   a_reload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reload_valid |-> (reload_value == '0))
      else $error("reload value is not zero without a reload");

   // Full charge needs an in-window sample, which also clears over-voltage.
   a_full_over_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(full_charge && over_voltage))
      else $error("full charge and over-voltage both set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(reload_value)
         && $stable(drive_on))
      else $error("stalled response item changed");

endmodule

bind hv_charge_pd_supervisor hvcps_checker u_hvcps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .drive_on     (rsp.drive_on),
   .reload_valid (rsp.reload_valid),
   .reload_value (rsp.reload_value),
   .full_charge  (rsp.full_charge),
   .over_voltage (rsp.over_voltage)
);
